/* src/mtc_pkg.sv */
package mtc_pkg;

    // field and datapath widths
    localparam int WORD_W        = 16;
    localparam int OUT_W         = 24;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_W         = 64;
    localparam int QUO_W         = 24;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_XY_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XY_COMMON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET  = 3'd3;

    // overflow codes of the sensor
    localparam logic signed [12:0] XY_OVF = -13'sd4096;
    localparam logic signed [14:0] Z_OVF  = -15'sd16384;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [CFG_W-1:0] xy_gain;
        logic [CFG_W-1:0] xy_common;
        logic [CFG_W-1:0] z_gain;
        logic [CFG_W-1:0] z_offset;
    } cfg_t;

    // one classified sample
    typedef struct packed {
        logic signed [12:0] mx;
        logic signed [12:0] my;
        logic signed [14:0] mz;
        logic        [13:0] r;
        logic signed [17:0] d;
        logic        [2:0]  inv;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_SUM,
        BK_MUL3,
        BK_NUM,
        BK_ABS,
        BK_GO,
        BK_DIV,
        BK_WB
    } back_state_t;

    function automatic logic [NUM_W-1:0] mag64(input logic signed [NUM_W-1:0] v);
        return v[NUM_W-1] ? (~v + NUM_W'(1)) : v;
    endfunction

    // apply sign and clamp a rounded magnitude to the output range
    function automatic logic [OUT_W-1:0] sign_sat(input logic neg, input logic ovf,
                                                   input logic [QUO_W-1:0] q);
        logic [OUT_W-1:0] res;
        if (neg)
        begin
            if (ovf || q[QUO_W-1])
                res = OUT_NEG_MAX;
            else
                res = ~q + OUT_W'(1);
        end
        else
        begin
            if (ovf || q[QUO_W-1])
                res = OUT_POS_MAX;
            else
                res = q;
        end
        return res;
    endfunction

endpackage

/* src/mtc_channels.sv */
interface mtc_in_if;
    import mtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] z_word;
    logic [WORD_W-1:0] hall_word;

    modport source (output valid, x_word, y_word, z_word, hall_word, input ready);
    modport sink (input valid, x_word, y_word, z_word, hall_word, output ready);
endinterface

interface mtc_out_if;
    import mtc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] field_x;
    logic signed [OUT_W-1:0] field_y;
    logic signed [OUT_W-1:0] field_z;
    logic [2:0]              invalid_axes;

    modport source (output valid, field_x, field_y, field_z, invalid_axes, input ready);
    modport sink (input valid, field_x, field_y, field_z, invalid_axes, output ready);
endinterface

/* src/mtc_front.sv */
module mtc_front (
    mtc_in_if.sink          in_ch,
    input  mtc_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            push,
    output mtc_pkg::item_t  item
);
    import mtc_pkg::*;

    logic [15:0] s;
    logic [15:0] z1;
    logic [15:0] z2;

    assign s  = cfg.xy_common[31:16];
    assign z1 = cfg.z_gain[15:0];
    assign z2 = cfg.z_gain[31:16];

    // take a request whenever the queue has room
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    // unpack the raw words and flag axes that cannot be compensated
    always_comb
    begin
        item.mx  = in_ch.x_word[15:3];
        item.my  = in_ch.y_word[15:3];
        item.mz  = in_ch.z_word[15:1];
        item.r   = in_ch.hall_word[15:2];
        item.d   = $signed({2'b00, s}) - $signed({4'b0000, in_ch.hall_word[15:2]});
        item.inv[0] = (item.mx == XY_OVF) || (item.r == '0) || (s == '0);
        item.inv[1] = (item.my == XY_OVF) || (item.r == '0) || (s == '0);
        item.inv[2] = (item.mz == Z_OVF) || (item.r == '0) || (s == '0)
                      || (z1 == '0) || (z2 == '0);
    end

endmodule

/* src/mtc_queue.sv */
module mtc_queue #(
    parameter int DEPTH = mtc_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mtc_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output mtc_pkg::item_t  head
);
    import mtc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

/* src/mtc_div.sv */
module mtc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mtc_pkg::NUM_W-1:0] num,
    input  logic [mtc_pkg::NUM_W-1:0] den,
    output logic                      done,
    output logic                      ovf,
    output logic [mtc_pkg::QUO_W-1:0] quo
);
    import mtc_pkg::*;

    localparam int SH_W  = NUM_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [SH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic             ge;

    assign ge   = {{QUO_W{1'b0}}, rem_reg} >= dsh_reg;
    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {{QUO_W{1'b0}}, den} << (QUO_W - 1);
            quo_reg <= '0;
            ovf_reg <= {{QUO_W{1'b0}}, num} >= {den, {QUO_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

/* src/mtc_back.sv */
module mtc_back #(
    parameter int OUT_FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mtc_pkg::cfg_t   cfg,
    input  logic            q_not_empty,
    input  mtc_pkg::item_t  q_head,
    output logic            pop,
    mtc_out_if.source       out_ch
);
    import mtc_pkg::*;

    localparam int DEN_SH = 17 - OUT_FRAC_BITS;
    localparam int NUM_SH = 9 + OUT_FRAC_BITS;

    back_state_t state_reg;
    back_state_t state_next;
    logic        div_start;
    logic        wb_load;
    logic [2:0]  div_done;
    logic [2:0]  div_ovf;
    logic [QUO_W-1:0] div_quo [3];

    item_t item_reg;

    // trim fields
    logic signed [7:0]  x1, y1, x2, y2, xy2;
    logic signed [8:0]  xy1;
    logic signed [9:0]  x2o, y2o;
    logic signed [16:0] z1;
    logic signed [15:0] z2, z3, z4;
    logic signed [14:0] r_s;
    logic signed [17:0] nd;
    logic signed [22:0] ph, pl;

    assign x1  = cfg.xy_gain[7:0];
    assign y1  = cfg.xy_gain[15:8];
    assign x2  = cfg.xy_gain[23:16];
    assign y2  = cfg.xy_gain[31:24];
    assign xy1 = $signed({1'b0, cfg.xy_common[7:0]});
    assign xy2 = cfg.xy_common[15:8];
    assign z1  = $signed({1'b0, cfg.z_gain[15:0]});
    assign z2  = cfg.z_gain[31:16];
    assign z3  = cfg.z_offset[15:0];
    assign z4  = cfg.z_offset[31:16];
    assign x2o = 10'(x2) + 10'sd160;
    assign y2o = 10'(y2) + 10'sd160;
    assign r_s = $signed({1'b0, item_reg.r});
    assign nd  = -item_reg.d;

    // intermediate products and sums
    logic signed [35:0] d2_reg;
    logic signed [29:0] r2_reg;
    logic signed [32:0] dr_reg;
    logic signed [22:0] gx_reg, gy_reg;
    logic signed [31:0] zq_reg;
    logic signed [33:0] z3rs_reg;
    logic signed [16:0] zm_reg;
    logic signed [43:0] t1_reg;
    logic signed [41:0] t2_reg;
    logic signed [37:0] x1r2_reg, y1r2_reg;
    logic signed [32:0] qz_reg;
    logic signed [34:0] z5_reg;
    logic signed [44:0] p_reg;
    logic signed [45:0] mxh_reg, mxl_reg, myh_reg, myl_reg;
    logic signed [NUM_W-1:0] n_reg [3];
    logic signed [NUM_W-1:0] den_reg [3];
    logic              qzero_reg;
    logic [NUM_W-1:0]  nu_reg [3];
    logic [NUM_W-1:0]  du_reg [3];
    logic [2:0]        neg_reg;
    logic [NUM_W-1:0]  mag_n [3];
    logic [NUM_W-1:0]  mag_d [3];

    assign ph = $signed(p_reg[44:22]);
    assign pl = $signed({1'b0, p_reg[21:0]});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag_n[a] = mag64(n_reg[a]);
            mag_d[a] = mag64(den_reg[a]);
        end
    end

    // datapath, one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                    item_reg <= q_head;
            end
            BK_MUL1:
            begin
                d2_reg   <= item_reg.d * item_reg.d;
                r2_reg   <= r_s * r_s;
                dr_reg   <= item_reg.d * r_s;
                gx_reg   <= item_reg.mx * x2o;
                gy_reg   <= item_reg.my * y2o;
                zq_reg   <= z1 * r_s;
                z3rs_reg <= z3 * nd;
                zm_reg   <= 17'(item_reg.mz) - 17'(z4);
            end
            BK_MUL2:
            begin
                t1_reg   <= xy2 * d2_reg;
                t2_reg   <= xy1 * dr_reg;
                x1r2_reg <= x1 * r2_reg;
                y1r2_reg <= y1 * r2_reg;
                qz_reg   <= (33'(z2) <<< 15) + 33'(zq_reg);
                z5_reg   <= (35'(zm_reg) <<< 17) - 35'(z3rs_reg);
            end
            BK_SUM:
            begin
                p_reg <= 45'(t1_reg) + 45'(t2_reg) + (45'(r2_reg) <<< 8);
            end
            BK_MUL3:
            begin
                mxh_reg <= gx_reg * ph;
                mxl_reg <= gx_reg * pl;
                myh_reg <= gy_reg * ph;
                myl_reg <= gy_reg * pl;
            end
            BK_NUM:
            begin
                n_reg[0]   <= (NUM_W'(mxh_reg) <<< 22) + NUM_W'(mxl_reg)
                              + (NUM_W'(x1r2_reg) <<< 16);
                n_reg[1]   <= (NUM_W'(myh_reg) <<< 22) + NUM_W'(myl_reg)
                              + (NUM_W'(y1r2_reg) <<< 16);
                n_reg[2]   <= NUM_W'(z5_reg) <<< NUM_SH;
                den_reg[0] <= NUM_W'(r2_reg) <<< DEN_SH;
                den_reg[1] <= NUM_W'(r2_reg) <<< DEN_SH;
                den_reg[2] <= NUM_W'(qz_reg);
                qzero_reg  <= (qz_reg == '0);
            end
            BK_ABS:
            begin
                // round half away: (2|n| + |d|) / (2|d|)
                for (int a = 0; a < 3; a++)
                begin
                    nu_reg[a]  <= (mag_n[a] << 1) + mag_d[a];
                    du_reg[a]  <= mag_d[a] << 1;
                    neg_reg[a] <= n_reg[a][NUM_W-1] ^ den_reg[a][NUM_W-1];
                end
            end
            default:
            begin
            end
        endcase
    end

    // shared-nothing dividers, one per axis, run together
    for (genvar a = 0; a < 3; a++)
    begin : g_div
        mtc_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (nu_reg[a]),
            .den   (du_reg[a]),
            .done  (div_done[a]),
            .ovf   (div_ovf[a]),
            .quo   (div_quo[a])
        );
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        wb_load    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_MUL1;
                end
            end
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_SUM;
            BK_SUM:  state_next = BK_MUL3;
            BK_MUL3: state_next = BK_NUM;
            BK_NUM:  state_next = BK_ABS;
            BK_ABS:  state_next = BK_GO;
            BK_GO:
            begin
                div_start  = 1'b1;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (&div_done)
                    state_next = BK_WB;
            end
            BK_WB:
            begin
                if (!out_ch.valid || out_ch.ready)
                begin
                    wb_load    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [2:0]              inv_reg;
    logic [2:0]              inv_all;

    assign inv_all = item_reg.inv | {qzero_reg, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wb_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wb_load)
        begin
            fx_reg  <= inv_all[0] ? '0 : sign_sat(neg_reg[0], div_ovf[0], div_quo[0]);
            fy_reg  <= inv_all[1] ? '0 : sign_sat(neg_reg[1], div_ovf[1], div_quo[1]);
            fz_reg  <= inv_all[2] ? '0 : sign_sat(neg_reg[2], div_ovf[2], div_quo[2]);
            inv_reg <= inv_all;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.field_x      = fx_reg;
    assign out_ch.field_y      = fy_reg;
    assign out_ch.field_z      = fz_reg;
    assign out_ch.invalid_axes = inv_reg;

endmodule

/* src/magnetometer_trim_compensation_top.sv */
// Channel  Dir  Payload                                        Handshake
// in_ch    in   x_word, y_word, z_word, hall_word (16 b each)   valid/ready
// out_ch   out  field_x/y/z (24 b signed), invalid_axes (3 b)    valid/ready
// cfg      in   cfg_index (3 b), cfg_wdata (32 b)               cfg_we
//
// In the back end each sample goes through 8 sequencer steps for the pop,
// products and sums, then the three bit-serial dividers (24 quotient bits
// each), and one write-back step that waits until the output is free. Up
// to two samples wait in the queue, so input requests are taken while a
// result is held.
// Reset clears the trim registers, queue and sequencer; no sweep follows.
module magnetometer_trim_compensation_top #(
    parameter int OUT_FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mtc_in_if.sink                        in_ch,
    mtc_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [mtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mtc_pkg::CFG_W-1:0]     cfg_wdata
);
    import mtc_pkg::*;

    cfg_t  cfg_reg;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_not_empty;
    item_t push_item;
    item_t q_head;

    // trim registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XY_GAIN:   cfg_reg.xy_gain   <= cfg_wdata;
                REG_XY_COMMON: cfg_reg.xy_common <= cfg_wdata;
                REG_Z_GAIN:    cfg_reg.z_gain    <= cfg_wdata;
                REG_Z_OFFSET:  cfg_reg.z_offset  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    mtc_front u_front (
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push),
        .item   (push_item)
    );

    mtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mtc_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

/* src/mtc_checker.sv */
module mtc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] field_x,
    input logic [23:0] field_y,
    input logic [23:0] field_z,
    input logic [2:0]  invalid_axes
);
    // requests taken but not yet delivered
    logic [2:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if ((in_valid && in_ready) && !(out_valid && out_ready))
            pend_reg <= pend_reg + 3'd1;
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
            pend_reg <= pend_reg - 3'd1;
    end

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result without a pending request");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!invalid_axes[0] || field_x == '0)
                   && (!invalid_axes[1] || field_y == '0)
                   && (!invalid_axes[2] || field_z == '0))
        else $error("invalid axis carries a non-zero value");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(field_x) && $stable(field_y)
                                    && $stable(field_z) && $stable(invalid_axes))
        else $error("result changed while stalled");

endmodule

bind magnetometer_trim_compensation_top mtc_checker u_mtc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .field_x      (out_ch.field_x),
    .field_y      (out_ch.field_y),
    .field_z      (out_ch.field_z),
    .invalid_axes (out_ch.invalid_axes)
);
